### rtl/core/motpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motpp_pkg: shared types and constants of the position loop
// Holds the action codes, the gain reset value and the request that the
// position stage hands to the command scaling stage.
// ----------------------------------------------------------------------------
package motpp_pkg;

    // Action codes of an input request.
    typedef enum logic [1:0] {
        ACT_TICK      = 2'd0,
        ACT_ROTATE    = 2'd1,
        ACT_SET_SPEED = 2'd2,
        ACT_READ      = 2'd3
    } t_action;

    // Field widths fixed by the interface.
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned ERR_W   = 32;
    localparam int unsigned DIST_W  = 32;

    // Default fraction bits of the gain and its reset value (2.0 in Q8.8).
    localparam int unsigned GAIN_FRAC_BITS_DEF = 8;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd512;

    // Most negative speed accepted; -32768 is taken as this value.
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -16'sd32767;

    // Request from the position stage to the command scaling stage.
    typedef struct packed {
        logic                      track;      // tick while moving: scale the error
        logic                      done;       // error inside +/-1, move ends
        logic                      err_neg;    // sign of the updated error
        logic [ERR_W-1:0]          err_abs;    // magnitude of the updated error
        logic signed [SPEED_W-1:0] limit;      // speed limit in force for this tick
        logic signed [SPEED_W-1:0] cmd_direct; // set point for set-speed requests
        logic                      cmd_valid;
        logic                      busy;
        logic [DIST_W-1:0]         distance;
    } t_scale_req;

endpackage

### rtl/core/motpp_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motpp_scale: speed set point from the position error
// Multiplies the error magnitude by the unsigned fixed-point gain, truncates
// toward zero, clamps to the speed limit and restores the sign.
// ----------------------------------------------------------------------------
module motpp_scale
    import motpp_pkg::*;
#(
    parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  t_scale_req                 i_req,
    input  logic [GAIN_W-1:0]          i_gain,
    output logic signed [SPEED_W-1:0]  o_cmd
);

    localparam int unsigned PROD_W = ERR_W + GAIN_W;
    localparam int unsigned MAG_W  = PROD_W - GAIN_FRAC_BITS;

    logic [PROD_W-1:0]  w_prod;
    logic [MAG_W-1:0]   w_mag;
    logic [MAG_W-1:0]   w_lim_mag;
    logic [SPEED_W-1:0] w_lim_abs;
    logic [SPEED_W-1:0] w_mag_lo;
    logic               w_over;

    // Magnitude of the error times the gain, fraction bits dropped.
    assign w_prod = PROD_W'(i_req.err_abs) * PROD_W'(i_gain);
    assign w_mag  = w_prod[PROD_W-1:GAIN_FRAC_BITS];

    // The limit never holds -32768, so its magnitude fits in 15 bits.
    assign w_lim_abs = i_req.limit[SPEED_W-1] ? (~i_req.limit + 1'b1) : i_req.limit;
    assign w_lim_mag = MAG_W'(w_lim_abs);
    assign w_over    = w_mag > w_lim_mag;
    assign w_mag_lo  = w_mag[SPEED_W-1:0];

    // Select the set point: direct value, zero at end of move, limit or scaled error.
    always_comb begin
        if (!i_req.track) begin
            o_cmd = i_req.cmd_direct;
        end else if (i_req.done) begin
            o_cmd = '0;
        end else if (w_over) begin
            o_cmd = i_req.limit;
        end else if (i_req.err_neg) begin
            o_cmd = -$signed(w_mag_lo);
        end else begin
            o_cmd = $signed(w_mag_lo);
        end
    end

endmodule

### rtl/core/motor_position_p_loop_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_position_p_loop_unit: proportional position loop
// Position loop over an external speed loop: rotate, tick, set speed limit
// and read-and-clear distance requests, one result per request.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle unless the output stalls; each
// result passes the second-stage and result registers. The first stage
// updates the position error (subtract and saturate), the move state and
// the distance accumulator, so that back-to-back requests see the updated
// state; the second stage holds the single 32x16 multiplier that scales the
// error by the gain and clamps it to the speed limit. Two requests can be
// held while the output is stalled. The gain register may be written only
// while no request is in flight.
module motor_position_p_loop_unit
    import motpp_pkg::*;
#(
    parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Request channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_action,
    input  logic signed [SPEED_W-1:0]  i_travel,
    input  logic signed [SPEED_W-1:0]  i_angle,
    input  logic signed [SPEED_W-1:0]  i_speed,
    // Result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SPEED_W-1:0]  o_speed_command,
    output logic                       o_command_valid,
    output logic                       o_busy_res,
    output logic signed [DIST_W-1:0]   o_distance_total,
    // Gain register write
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [GAIN_W-1:0]          i_cfg_gain
);

    // State
    logic [GAIN_W-1:0]         r_gain;
    logic signed [ERR_W-1:0]   r_err,   n_err;
    logic signed [SPEED_W-1:0] r_limit, n_limit;
    logic                      r_moving, n_moving;
    logic [DIST_W-1:0]         r_dist,  n_dist;

    // Pipeline registers
    logic                      r_s2_valid;
    t_scale_req                r_s2, n_s2;
    logic                      r_out_valid;
    logic signed [SPEED_W-1:0] r_cmd;
    logic                      r_cmd_valid;
    logic                      r_busy;
    logic [DIST_W-1:0]         r_dist_out;

    logic                      w_out_free;
    logic                      w_s2_adv;
    logic                      w_in_fire;
    t_action                   w_action;
    logic signed [ERR_W:0]     w_diff;
    logic signed [ERR_W-1:0]   w_err_sat;
    logic [ERR_W-1:0]          w_err_abs;
    logic                      w_done;
    logic signed [SPEED_W-1:0] w_speed_cl;
    logic signed [SPEED_W-1:0] w_rot_speed;
    logic signed [SPEED_W:0]   w_rot_angle;
    logic [DIST_W-1:0]         w_dist_add;
    logic signed [SPEED_W-1:0] w_cmd;

    // Handshake: each stage advances when the one after it has room.
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_s2_adv    = r_s2_valid && w_out_free;
    assign o_in_ready  = !r_s2_valid || w_out_free;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign w_action    = t_action'(i_action);

    // Error update: subtract the travel and saturate to 32 bits.
    assign w_diff = {r_err[ERR_W-1], r_err} - (ERR_W+1)'(i_travel);
    always_comb begin
        if (w_diff[ERR_W] != w_diff[ERR_W-1]) begin
            w_err_sat = w_diff[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}}
                                      : {1'b0, {(ERR_W-1){1'b1}}};
        end else begin
            w_err_sat = w_diff[ERR_W-1:0];
        end
    end
    assign w_err_abs = w_err_sat[ERR_W-1] ? (~w_err_sat + 1'b1) : w_err_sat;
    assign w_done    = (w_err_sat == '0) || (w_err_sat == ERR_W'(1))
                    || (w_err_sat == '1);

    assign w_dist_add = r_dist + DIST_W'(i_travel);

    // Speed clamp and sign normalization for rotate.
    assign w_speed_cl = (i_speed == {1'b1, {(SPEED_W-1){1'b0}}}) ? SPEED_MIN : i_speed;
    always_comb begin
        w_rot_speed = w_speed_cl;
        w_rot_angle = (SPEED_W+1)'(i_angle);
        priority if (i_angle < 0 && w_speed_cl > 0) begin
            w_rot_speed = -w_speed_cl;
        end else if (w_speed_cl < 0 && i_angle > 0) begin
            w_rot_angle = -(SPEED_W+1)'(i_angle);
        end else if (w_speed_cl < 0 && i_angle < 0) begin
            w_rot_angle = -(SPEED_W+1)'(i_angle);
            w_rot_speed = -w_speed_cl;
        end else begin
            // Signs already agree or one is zero: angle and speed pass unchanged.
            w_rot_speed = w_speed_cl;
            w_rot_angle = (SPEED_W+1)'(i_angle);
        end
    end

    // First stage: state update and the request for the scaling stage.
    always_comb begin
        n_err    = r_err;
        n_limit  = r_limit;
        n_moving = r_moving;
        n_dist   = r_dist;
        n_s2            = '0;
        n_s2.err_neg    = w_err_sat[ERR_W-1];
        n_s2.err_abs    = w_err_abs;
        n_s2.done       = w_done;
        n_s2.limit      = r_limit;
        unique case (w_action)
            ACT_TICK: begin
                n_dist = w_dist_add;
                if (r_moving) begin
                    n_s2.track     = 1'b1;
                    n_s2.cmd_valid = 1'b1;
                    if (w_done) begin
                        n_err    = '0;
                        n_limit  = '0;
                        n_moving = 1'b0;
                    end else begin
                        n_err = w_err_sat;
                    end
                end
            end
            ACT_ROTATE: begin
                if (!r_moving) begin
                    n_dist   = w_dist_add;
                    n_err    = ERR_W'(w_rot_angle);
                    n_limit  = w_rot_speed;
                    n_moving = 1'b1;
                end
            end
            ACT_SET_SPEED: begin
                n_limit         = w_speed_cl;
                n_s2.cmd_direct = w_speed_cl;
                n_s2.cmd_valid  = 1'b1;
            end
            ACT_READ: begin
                n_s2.distance = r_dist;
                n_dist        = '0;
            end
            default: begin
                n_dist = r_dist;
            end
        endcase
        n_s2.busy = n_moving;
    end

    // State registers and gain register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_err    <= '0;
            r_limit  <= '0;
            r_moving <= 1'b0;
            r_dist   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_gain <= i_cfg_gain;
            end
            if (w_in_fire) begin
                r_err    <= n_err;
                r_limit  <= n_limit;
                r_moving <= n_moving;
                r_dist   <= n_dist;
            end
        end
    end

    // Second stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s2_valid <= 1'b1;
        end else if (w_s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s2 <= n_s2;
        end
    end

    // Gain scaling and limit clamp.
    motpp_scale #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_scale (
        .i_req  (r_s2),
        .i_gain (r_gain),
        .o_cmd  (w_cmd)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_cmd       <= w_cmd;
            r_cmd_valid <= r_s2.cmd_valid;
            r_busy      <= r_s2.busy;
            r_dist_out  <= r_s2.distance;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_speed_command  = r_cmd;
    assign o_command_valid  = r_cmd_valid;
    assign o_busy_res       = r_busy;
    assign o_distance_total = $signed(r_dist_out);

    // An idle loop always holds a zero position error.
    a_idle_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_moving |-> (r_err == '0))
        else $error("position error not zero while idle");

    // A result without a set point carries a zero command.
    a_no_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_cmd_valid) |-> (r_cmd == '0))
        else $error("nonzero command without set point");

    // A distance readout never comes with a set point.
    a_dist_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dist_out != '0) |-> !r_cmd_valid)
        else $error("distance and set point in one result");

    // A stalled second stage keeps its request.
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !w_out_free) |=> (r_s2_valid && $stable(r_s2)))
        else $error("second stage request lost during stall");

endmodule

### tb/motor_position_p_loop_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_position_p_loop_checker: result checker for the position loop
// Watches the request, result and gain channels of the position loop. Each
// accepted request runs through a local model of the loop, and each accepted
// result is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module motor_position_p_loop_checker
    import motpp_pkg::*;
#(
    parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [1:0]                 i_action,
    input  logic signed [SPEED_W-1:0]  i_travel,
    input  logic signed [SPEED_W-1:0]  i_angle,
    input  logic signed [SPEED_W-1:0]  i_speed,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [SPEED_W-1:0]  i_speed_command,
    input  logic                       i_command_valid,
    input  logic                       i_busy_res,
    input  logic signed [DIST_W-1:0]   i_distance_total,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [GAIN_W-1:0]          i_cfg_gain,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam longint ERR_MAX = 64'sd2147483647;
    localparam longint ERR_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_command;
        logic                      command_valid;
        logic                      busy_res;
        logic signed [DIST_W-1:0]  distance_total;
    } t_loop_result;

    // Local copy of the loop state and of the gain register.
    logic [GAIN_W-1:0]          gain_q;
    int                         err_deg;
    logic signed [SPEED_W-1:0]  limit;
    bit                         moving;
    logic [DIST_W-1:0]          dist_sum;
    t_loop_result               results_due [$];
    int                         mismatches = 0;

    // One request through the position loop: updates the state and returns
    // the result it causes.
    function automatic t_loop_result run_position_loop(
        input logic [1:0]                act,
        input logic signed [SPEED_W-1:0] trv,
        input logic signed [SPEED_W-1:0] ang,
        input logic signed [SPEED_W-1:0] spd
    );
        t_loop_result res;
        longint       err_next;
        longint       mag;
        longint       lim_mag;
        int           ang_n;
        int           spd_n;
        res = '0;
        // The most negative speed is taken as its negated maximum.
        spd_n = (spd < SPEED_MIN) ? int'(SPEED_MIN) : int'(spd);
        case (act)
            ACT_TICK: begin
                dist_sum = dist_sum + {{(DIST_W-SPEED_W){trv[SPEED_W-1]}}, trv};
                if (moving) begin
                    err_next = longint'(err_deg) - longint'(trv);
                    if (err_next > ERR_MAX) err_next = ERR_MAX;
                    if (err_next < ERR_MIN) err_next = ERR_MIN;
                    err_deg = int'(err_next);
                    mag = ((err_next < 0) ? -err_next : err_next) * longint'(gain_q);
                    mag = mag >> GAIN_FRAC_BITS;
                    lim_mag = (limit < 0) ? -longint'(limit) : longint'(limit);
                    // A set point beyond the limit becomes the stored limit.
                    if (mag > lim_mag) begin
                        res.speed_command = limit;
                    end else begin
                        res.speed_command = SPEED_W'((err_next < 0) ? -mag : mag);
                    end
                    // Inside +/-1 the move ends with a zero command.
                    if (err_deg < 2 && err_deg > -2) begin
                        moving = 1'b0;
                        limit = '0;
                        err_deg = 0;
                        res.speed_command = '0;
                    end
                    res.command_valid = 1'b1;
                end
            end
            ACT_ROTATE: begin
                // A rotate during a move is dropped, travel included.
                if (!moving) begin
                    ang_n = int'(ang);
                    if (ang_n < 0 && spd_n > 0) begin
                        spd_n = -spd_n;
                    end else if (spd_n < 0 && ang_n > 0) begin
                        ang_n = -ang_n;
                    end else if (spd_n < 0 && ang_n < 0) begin
                        ang_n = -ang_n;
                        spd_n = -spd_n;
                    end
                    dist_sum = dist_sum + {{(DIST_W-SPEED_W){trv[SPEED_W-1]}}, trv};
                    err_deg = ang_n;
                    limit = SPEED_W'(spd_n);
                    moving = 1'b1;
                end
            end
            ACT_SET_SPEED: begin
                limit = SPEED_W'(spd_n);
                res.speed_command = SPEED_W'(spd_n);
                res.command_valid = 1'b1;
            end
            default: begin
                res.distance_total = dist_sum;
                dist_sum = '0;
            end
        endcase
        res.busy_res = moving;
        return res;
    endfunction

    // Check results first, then take new requests, so that a result can only
    // match a request accepted at an earlier edge.
    always @(posedge i_clk) begin
        t_loop_result want;
        if (!i_rst_n) begin
            gain_q = GAIN_RESET;
            err_deg = 0;
            limit = '0;
            moving = 1'b0;
            dist_sum = '0;
            results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result returned with no request outstanding");
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (i_speed_command !== want.speed_command) begin
                        $error("speed_command: expected %0d, got %0d",
                               want.speed_command, i_speed_command);
                        mismatches++;
                    end
                    if (i_command_valid !== want.command_valid) begin
                        $error("command_valid: expected %0d, got %0d",
                               want.command_valid, i_command_valid);
                        mismatches++;
                    end
                    if (i_busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0d, got %0d",
                               want.busy_res, i_busy_res);
                        mismatches++;
                    end
                    if (i_distance_total !== want.distance_total) begin
                        $error("distance_total: expected %0d, got %0d",
                               want.distance_total, i_distance_total);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                gain_q = i_cfg_gain;
            end
            if (i_in_valid && i_in_ready) begin
                results_due.push_back(run_position_loop(i_action, i_travel,
                                                        i_angle, i_speed));
            end
        end
        o_fail_count <= mismatches;
        o_pending <= results_due.size();
    end

endmodule

### tb/tb_motor_position_p_loop_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_position_p_loop_unit: testbench of the proportional position loop
// Drives directed and random request streams through the loop under several
// gain settings, with random gaps on the request side and random stalls on
// the result side. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_motor_position_p_loop_unit;
    import motpp_pkg::*;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int SETTLE_CYCLES   = 6;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_action = ACT_TICK;
    logic signed [SPEED_W-1:0] i_travel = '0;
    logic signed [SPEED_W-1:0] i_angle = '0;
    logic signed [SPEED_W-1:0] i_speed = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [SPEED_W-1:0] o_speed_command;
    logic                      o_command_valid;
    logic                      o_busy_res;
    logic signed [DIST_W-1:0]  o_distance_total;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [GAIN_W-1:0]         i_cfg_gain = '0;

    int     fail_count;
    int     results_pending;
    bit     idle_on = 1'b1;
    int     stall_left = 0;
    int     items_sent = 0;
    // Rough view of the move in progress, used only to steer the stimulus.
    bit     move_open = 1'b0;
    longint move_error = 0;

    always #1 i_clk = ~i_clk;

    motor_position_p_loop_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_travel         (i_travel),
        .i_angle          (i_angle),
        .i_speed          (i_speed),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_speed_command  (o_speed_command),
        .o_command_valid  (o_command_valid),
        .o_busy_res       (o_busy_res),
        .o_distance_total (o_distance_total),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_gain       (i_cfg_gain)
    );

    motor_position_p_loop_checker loop_monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_travel         (i_travel),
        .i_angle          (i_angle),
        .i_speed          (i_speed),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_speed_command  (o_speed_command),
        .i_command_valid  (o_command_valid),
        .i_busy_res       (o_busy_res),
        .i_distance_total (o_distance_total),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_gain       (i_cfg_gain),
        .o_fail_count     (fail_count),
        .o_pending        (results_pending)
    );

    // Result side: ready drops for bursts of random length while idling is on.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9);
        end
        i_out_ready <= (stall_left == 0);
    end

    // Present one request and hold it until accepted. Valid stays high after
    // acceptance unless a gap follows, so back-to-back requests are seamless.
    task automatic send_request(
        input t_action                   act,
        input logic signed [SPEED_W-1:0] trv,
        input logic signed [SPEED_W-1:0] ang,
        input logic signed [SPEED_W-1:0] spd
    );
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_travel <= trv;
        i_angle <= ang;
        i_speed <= spd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        // Track the move so that later ticks can bring it to an end.
        if (act == ACT_TICK && move_open) begin
            move_error = move_error - longint'(trv);
            if (move_error < 2 && move_error > -2) move_open = 1'b0;
        end else if (act == ACT_ROTATE && !move_open) begin
            move_error = (spd < 0) ? -longint'(ang) : longint'(ang);
            move_open = 1'b1;
        end
    endtask

    // Ticks toward an error of -1, 0 or +1, which ends the move; travel is clamped.
    task automatic close_move();
        longint trv;
        while (move_open) begin
            trv = move_error + 1 - longint'($urandom_range(0, 2));
            if (trv > 32767) trv = longint'($urandom_range(16384, 32767));
            if (trv < -32768) trv = -longint'($urandom_range(16384, 32768));
            send_request(ACT_TICK, SPEED_W'(trv), SPEED_W'($urandom), SPEED_W'($urandom));
        end
    endtask

    // A well-formed move: rotate, a few tracking ticks mixed with other
    // requests, then the closing ticks.
    task automatic run_move();
        logic signed [SPEED_W-1:0] ang;
        logic signed [SPEED_W-1:0] spd;
        longint                    trv;
        ang = ($urandom_range(0, 3) == 0) ? SPEED_W'($urandom)
                                          : SPEED_W'($urandom_range(0, 600)) - 16'sd300;
        spd = ($urandom_range(0, 2) == 0) ? SPEED_W'($urandom)
                                          : SPEED_W'($urandom_range(0, 2000)) - 16'sd1000;
        send_request(ACT_ROTATE, SPEED_W'($urandom), ang, spd);
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
                0: send_request(ACT_SET_SPEED, SPEED_W'($urandom), SPEED_W'($urandom),
                                SPEED_W'($urandom));
                1: send_request(ACT_READ, SPEED_W'($urandom), SPEED_W'($urandom),
                                SPEED_W'($urandom));
                2: send_request(ACT_ROTATE, SPEED_W'($urandom), SPEED_W'($urandom),
                                SPEED_W'($urandom));
                3: send_request(ACT_TICK, SPEED_W'($urandom), SPEED_W'($urandom),
                                SPEED_W'($urandom));
                default: begin
                    trv = move_error / longint'($urandom_range(2, 5));
                    send_request(ACT_TICK, SPEED_W'(trv), SPEED_W'($urandom),
                                 SPEED_W'($urandom));
                end
            endcase
        end
        close_move();
    endtask

    // Let every outstanding result come back, then a quiet settling pause.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_gain <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Main stimulus.
    initial begin
        int phase;
        int phase_start;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle ticks and reads at the travel extremes.
        send_request(ACT_READ, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_request(ACT_TICK, 16'sh7FFF, 16'sh0000, 16'sh0000);
        send_request(ACT_TICK, -16'sh8000, 16'sh0000, 16'sh0000);
        send_request(ACT_READ, 16'sh0000, -16'sh8000, -16'sh8000);
        // Speed limit writes, the most negative speed among them.
        send_request(ACT_SET_SPEED, 16'sh1234, 16'sh0000, -16'sh8000);
        send_request(ACT_SET_SPEED, 16'sh0000, 16'sh0000, 16'sh7FFF);
        send_request(ACT_SET_SPEED, 16'sh0000, 16'sh0000, 16'sh0000);
        // Negative angle with positive speed, a rotate during the move, and
        // a tick that lands exactly on target.
        send_request(ACT_ROTATE, 16'sh0005, -16'sh8000, 16'sh7FFF);
        send_request(ACT_ROTATE, 16'sh004D, 16'sh0064, 16'sh0064);
        send_request(ACT_TICK, -16'sh8000, 16'sh0000, 16'sh0000);
        // Positive angle with the most negative speed: set point held at
        // the negative limit, then the move ends at -1.
        send_request(ACT_ROTATE, 16'sh0000, 16'sh7FFF, -16'sh8000);
        send_request(ACT_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        send_request(ACT_TICK, -16'sh7FFE, 16'sh0000, 16'sh0000);
        // Both negative, then errors around the end-of-move bound.
        send_request(ACT_ROTATE, 16'sh0000, -16'sh0005, -16'sh0007);
        send_request(ACT_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        send_request(ACT_TICK, 16'sh0002, 16'sh0000, 16'sh0000);
        send_request(ACT_TICK, 16'sh0001, 16'sh0000, 16'sh0000);
        send_request(ACT_TICK, 16'sh0003, 16'sh0000, 16'sh0000);
        // Zero move, and a move with a limit change during it.
        send_request(ACT_ROTATE, 16'sh0000, 16'sh0000, 16'sh0000);
        send_request(ACT_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        send_request(ACT_ROTATE, 16'sh0000, 16'sh0001, 16'sh0001);
        send_request(ACT_TICK, -16'sh0001, 16'sh0000, 16'sh0000);
        send_request(ACT_SET_SPEED, 16'sh0000, 16'sh0000, 16'sh012C);
        close_move();
        send_request(ACT_READ, 16'sh0000, 16'sh0000, 16'sh0000);

        // Random phases under fixed and random gains; the last runs without idling.
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain_results();
                case (phase)
                    1: write_gain(16'hFFFF);
                    2: write_gain(16'h0000);
                    3: write_gain(16'h0001);
                    5: write_gain(GAIN_RESET);
                    default: write_gain(GAIN_W'($urandom));
                endcase
            end
            idle_on = (phase != PHASES - 1);
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 3) != 0) begin
                    run_move();
                end else begin
                    send_request(t_action'($urandom_range(0, 3)), SPEED_W'($urandom),
                                 SPEED_W'($urandom), SPEED_W'($urandom));
                end
            end
            close_move();
        end

        drain_results();
        if (fail_count == 0 && results_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
